// File: design/set_assoc_lru_writeback_cache_defines.svh
// assertion macros for the cache checker
`ifndef SET_ASSOC_LRU_WRITEBACK_CACHE_DEFINES_SVH
`define SET_ASSOC_LRU_WRITEBACK_CACHE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define SALC_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define SALC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/salc_pkg.sv
// shared constants for the set associative cache
`default_nettype none
package salc_pkg;
    localparam int unsigned CFG_WIDTH = 7;
    localparam int unsigned CNT_WIDTH = 32;
    localparam int unsigned WB_KEY_WIDTH = 32;
endpackage
`default_nettype wire

// File: design/set_assoc_lru_writeback_cache.sv
// set associative lru write-back key cache, tags only
//
//  channel  | dir | beat fields
//  s_axis   | in  | tdata: lookup_key, set_dirty
//  m_axis   | out | tdata: hit, writeback_valid, writeback_key, hit/miss/wb counts
//  cfg      | in  | cfg_data: sets_in_use
//
// an access goes from its accepting edge to its result beat in these steps:
// a shared subtractor forms key mod sets one key bit a cycle, then the set row is
// read, compared and written back.
// after reset a clearing pass over all SETS rows runs before the first beat is taken.
// s_axis_tready is low while an access is in work or its result waits on m_axis.
`default_nettype none
module set_assoc_lru_writeback_cache
    import salc_pkg::*;
#(
    parameter int SETS      = 64,
    parameter int WAYS      = 4,
    parameter int KEY_WIDTH = 32,
    localparam int DIN_W    = ((KEY_WIDTH + 1 + 7) / 8) * 8,
    localparam int DOUT_RAW = 2 + WB_KEY_WIDTH + 3 * CNT_WIDTH,
    localparam int DOUT_W   = ((DOUT_RAW + 7) / 8) * 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // lookup_key, set_dirty
    input  wire logic [DIN_W-1:0]     s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // hit, writeback_valid, writeback_key, hit_count, miss_count, writeback_count
    output logic [DOUT_W-1:0]         m_axis_tdata,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_WIDTH-1:0] cfg_data
);
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int BIT_W  = $clog2(KEY_WIDTH + 1);
    localparam int REM_W  = CFG_WIDTH + 1;
    localparam int ROW_W  = WAYS * (KEY_WIDTH + 2 + WAY_W);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_MOD, ST_READ, ST_CMP, ST_WRITE, ST_OUT
    } state_t;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] tag;
        logic                 valid;
        logic                 dirty;
        logic [WAY_W-1:0]     rank;
    } entry_t;

    state_t                  state_reg;
    logic [CFG_WIDTH-1:0]    sets_reg;
    logic [KEY_WIDTH-1:0]    key_reg;
    logic                    mark_reg;
    logic [BIT_W-1:0]        bit_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [CFG_WIDTH-1:0]    n_reg;
    logic [SET_W-1:0]        set_reg;
    logic [ROW_W-1:0]        row_mem [SETS];
    logic [ROW_W-1:0]        row_reg;
    logic [ROW_W-1:0]        row_next;
    logic                    hit_reg;
    logic                    wb_reg;
    logic [KEY_WIDTH-1:0]    wb_key_reg;
    logic [CNT_WIDTH-1:0]    hit_cnt_reg;
    logic [CNT_WIDTH-1:0]    miss_cnt_reg;
    logic [CNT_WIDTH-1:0]    wb_cnt_reg;
    logic [SET_W-1:0]        clr_reg;

    logic [CFG_WIDTH-1:0]    n_eff;
    logic [REM_W-1:0]        rem_shift;
    logic [REM_W-1:0]        rem_sub;
    entry_t                  ent [WAYS];
    entry_t                  upd [WAYS];
    logic                    c_hit;
    logic                    c_free;
    logic [WAY_W-1:0]        c_way;
    logic [WAY_W-1:0]        free_way;
    logic [WAY_W-1:0]        lru_way;
    logic [WAY_W-1:0]        old_rank;
    logic [ROW_W-1:0]        reset_row;

    always_comb begin
        if (sets_reg == '0) begin
            n_eff = CFG_WIDTH'(1);
        end else if (32'(sets_reg) > SETS) begin
            n_eff = CFG_WIDTH'(SETS);
        end else begin
            n_eff = sets_reg;
        end
    end

    // restoring remainder step over one key bit, msb first
    always_comb begin
        rem_shift = {rem_reg[REM_W-2:0], key_reg[KEY_WIDTH - 32'(bit_reg)]};
        rem_sub   = rem_shift - REM_W'(n_reg);
    end

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            reset_row[w*$bits(entry_t) +: $bits(entry_t)] =
                {{KEY_WIDTH{1'b0}}, 1'b0, 1'b0, WAY_W'(w)};
            ent[w] = entry_t'(row_reg[w*$bits(entry_t) +: $bits(entry_t)]);
        end
    end

    always_comb begin
        c_hit    = 1'b0;
        c_free   = 1'b0;
        c_way    = '0;
        free_way = '0;
        lru_way  = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (ent[w].valid && ent[w].tag == key_reg) begin
                c_hit = 1'b1;
                c_way = WAY_W'(w);
            end
            if (!ent[w].valid) begin
                c_free   = 1'b1;
                free_way = WAY_W'(w);
            end
            if (32'(ent[w].rank) == WAYS - 1) begin
                lru_way = WAY_W'(w);
            end
        end
        if (!c_hit) begin
            c_way = c_free ? free_way : lru_way;
        end
        old_rank = ent[c_way].rank;
        for (int w = 0; w < WAYS; w++) begin
            upd[w] = ent[w];
            if (ent[w].rank < old_rank) begin
                upd[w].rank = ent[w].rank + WAY_W'(1);
            end
            if (WAY_W'(w) == c_way) begin
                upd[w].rank = '0;
                if (!c_hit) begin
                    upd[w].tag   = key_reg;
                    upd[w].valid = 1'b1;
                    upd[w].dirty = 1'b0;
                end
                if (mark_reg) begin
                    upd[w].dirty = 1'b1;
                end
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            row_next[w*$bits(entry_t) +: $bits(entry_t)] = upd[w];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            row_mem[clr_reg] <= reset_row;
        end else if (state_reg == ST_WRITE) begin
            row_mem[set_reg] <= row_reg;
        end
        if (state_reg == ST_CMP) begin
            row_reg <= row_next;
        end else begin
            row_reg <= row_mem[set_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            sets_reg     <= CFG_WIDTH'(SETS);
            clr_reg      <= '0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            wb_cnt_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                sets_reg <= cfg_data;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + SET_W'(1);
                    if (32'(clr_reg) == SETS - 1) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        key_reg   <= s_axis_tdata[KEY_WIDTH-1:0];
                        mark_reg  <= s_axis_tdata[KEY_WIDTH];
                        n_reg     <= n_eff;
                        rem_reg   <= '0;
                        bit_reg   <= BIT_W'(1);
                        state_reg <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    rem_reg <= rem_sub[REM_W-1] ? rem_shift : rem_sub;
                    set_reg <= SET_W'(rem_sub[REM_W-1] ? rem_shift : rem_sub);
                    bit_reg <= bit_reg + BIT_W'(1);
                    if (32'(bit_reg) == KEY_WIDTH) begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    hit_reg    <= c_hit;
                    wb_reg     <= !c_hit && !c_free && ent[lru_way].dirty;
                    wb_key_reg <= (!c_hit && !c_free && ent[lru_way].dirty)
                                  ? ent[lru_way].tag : '0;
                    if (c_hit) begin
                        hit_cnt_reg <= hit_cnt_reg + CNT_WIDTH'(1);
                    end else begin
                        miss_cnt_reg <= miss_cnt_reg + CNT_WIDTH'(1);
                        if (!c_free && ent[lru_way].dirty) begin
                            wb_cnt_reg <= wb_cnt_reg + CNT_WIDTH'(1);
                        end
                    end
                    state_reg <= ST_WRITE;
                end
                ST_WRITE: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_axis_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = DOUT_W'({wb_cnt_reg, miss_cnt_reg, hit_cnt_reg,
                                    WB_KEY_WIDTH'(wb_key_reg), wb_reg, hit_reg});
endmodule
`default_nettype wire

// File: design/salc_checker.sv
// port level checker for the cache, bound to the top level
`default_nettype none
`include "set_assoc_lru_writeback_cache_defines.svh"
module salc_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [135:0] m_axis_tdata
);
    `SALC_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, m_axis_tvalid, !s_axis_tready, "accept while result pending")
    `SALC_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after accept")
    `SALC_ASSERT_IMPL(a_wb_miss, aclk, aresetn, m_axis_tvalid && m_axis_tdata[1], !m_axis_tdata[0], "writeback on hit")
    `SALC_ASSERT_IMPL(a_wb_key, aclk, aresetn, m_axis_tvalid && !m_axis_tdata[1], m_axis_tdata[33:2] == 32'd0, "writeback key without writeback")
endmodule

bind set_assoc_lru_writeback_cache salc_checker u_salc_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// File: tb/tb_top.sv
// testbench for the set associative lru write-back key cache
`default_nettype none

class cache_scoreboard;
    localparam int NSETS = 64;
    localparam int NWAYS = 4;

    bit [31:0] tags [NSETS][NWAYS];
    bit        valid [NSETS][NWAYS];
    bit        dirty [NSETS][NWAYS];
    int        rank [NSETS][NWAYS];
    bit [31:0] hits, misses, wbacks;
    bit [6:0]  sets_cfg;
    bit [129:0] pending [$];
    int        errors;

    function new();
        for (int s = 0; s < NSETS; s++)
            for (int w = 0; w < NWAYS; w++) begin
                tags[s][w] = 0;
                valid[s][w] = 0;
                dirty[s][w] = 0;
                rank[s][w] = w;
            end
        hits = 0;
        misses = 0;
        wbacks = 0;
        sets_cfg = 7'd64;
        errors = 0;
    endfunction

    function void set_sets(bit [6:0] v);
        sets_cfg = v;
    endfunction

    // model one access and queue the beat it should produce
    function void note_access(bit [31:0] key, bit mark);
        int n, s, way, old;
        bit hit, found, wb;
        bit [31:0] wb_key;
        n = sets_cfg;
        if (n == 0) n = 1;
        if (n > NSETS) n = NSETS;
        s = key % n;
        hit = 0;
        found = 0;
        wb = 0;
        wb_key = 0;
        way = 0;
        for (int w = 0; w < NWAYS; w++)
            if (!hit && valid[s][w] && tags[s][w] == key) begin
                hit = 1;
                way = w;
            end
        if (hit) begin
            hits++;
        end else begin
            misses++;
            for (int w = 0; w < NWAYS; w++)
                if (!found && !valid[s][w]) begin
                    found = 1;
                    way = w;
                end
            if (!found) begin
                for (int w = 0; w < NWAYS; w++)
                    if (rank[s][w] == NWAYS - 1) way = w;
                if (dirty[s][way]) begin
                    wb = 1;
                    wb_key = tags[s][way];
                    wbacks++;
                end
            end
            tags[s][way] = key;
            valid[s][way] = 1;
            dirty[s][way] = 0;
        end
        old = rank[s][way];
        for (int w = 0; w < NWAYS; w++)
            if (rank[s][w] < old) rank[s][w]++;
        rank[s][way] = 0;
        if (mark) dirty[s][way] = 1;
        pending.push_back({wbacks, misses, hits, wb_key, wb, hit});
    endfunction

    function void check_result(bit [135:0] got);
        bit [129:0] exp;
        if (pending.size() == 0) begin
            $error("result beat with nothing expected: %h", got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got[0] !== exp[0]) begin
            $error("hit: expected %0d actual %0d", exp[0], got[0]);
            errors++;
        end
        if (got[1] !== exp[1]) begin
            $error("writeback_valid: expected %0d actual %0d", exp[1], got[1]);
            errors++;
        end
        if (got[33:2] !== exp[33:2]) begin
            $error("writeback_key: expected %h actual %h", exp[33:2], got[33:2]);
            errors++;
        end
        if (got[65:34] !== exp[65:34]) begin
            $error("hit_count: expected %0d actual %0d", exp[65:34], got[65:34]);
            errors++;
        end
        if (got[97:66] !== exp[97:66]) begin
            $error("miss_count: expected %0d actual %0d", exp[97:66], got[97:66]);
            errors++;
        end
        if (got[129:98] !== exp[129:98]) begin
            $error("writeback_count: expected %0d actual %0d", exp[129:98], got[129:98]);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import salc_pkg::*;

    localparam int LIMIT = 1000000;

    logic          aclk = 0;
    logic          aresetn = 0;
    logic          s_axis_tvalid = 0;
    logic          s_axis_tready;
    // lookup_key, set_dirty
    logic [39:0]   s_axis_tdata = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 0;
    // hit, writeback_valid, writeback_key, hit_count, miss_count, writeback_count
    logic [135:0]  m_axis_tdata;
    logic          cfg_valid = 0;
    logic          cfg_ready;
    logic [CFG_WIDTH-1:0] cfg_data = '0;

    cache_scoreboard sb;
    int cycles = 0;
    int burst_left = 0;
    int stall_mode = 0;

    set_assoc_lru_writeback_cache dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver stall pattern: the mode is redrawn periodically among always, mostly and rarely ready
    always @(posedge aclk) begin
        if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    task automatic send_access(input bit [31:0] key, input bit mark);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 40);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, mark, key};
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_access(key, mark);
        burst_left--;
    endtask

    task automatic write_sets(input bit [6:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_sets(v);
    endtask

    function automatic bit [31:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(0, 300);
        if (r < 85) return {$urandom_range(0, 3) == 0 ? 24'hffffff : 24'h800000,
                            8'($urandom_range(0, 40))};
        return $urandom;
    endfunction

    initial begin
        bit [6:0] phase_sets [8];
        phase_sets = '{7'd1, 7'd0, 7'd127, 7'd7, 7'd64, 7'd3, 7'd33, 7'd65};
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, dirty eviction from a full set, hits
        send_access(32'h0, 1'b0);
        send_access(32'hffffffff, 1'b1);
        send_access(32'hffffffff, 1'b0);
        for (int i = 1; i <= 4; i++) send_access(32'(i * 64), 1'b1);
        send_access(32'd320, 1'b0);
        send_access(32'd384, 1'b0);
        send_access(32'd64 * 3, 1'b0);
        send_access(32'h0, 1'b1);
        send_access(32'h80000000, 1'b0);
        send_access(32'h7fffffff, 1'b1);
        send_access(32'd63, 1'b0);

        foreach (phase_sets[p]) begin
            write_sets(phase_sets[p]);
            for (int i = 0; i < 115; i++) send_access(pick_key(), 1'($urandom_range(0, 1)));
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

`default_nettype wire

// File: sim.f
+incdir+design
design/salc_pkg.sv
design/set_assoc_lru_writeback_cache.sv
design/salc_checker.sv
tb/tb_top.sv
